// ----- rtl/core/iirdf1_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf1_pkg
// shared types, widths and codes of the direct form I iir filter
// ----------------------------------------------------------------------------
package iirdf1_pkg;

  // tap count and storage depth
  localparam int MAX_TAPS = 8;
  localparam int DEPTH    = MAX_TAPS + 1;
  localparam int TAP_W    = $clog2(DEPTH);

  // data formats: samples q24.0, coefficients q8.24
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int FRAC_W   = 24;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 62;
  localparam int RND_W    = ACC_W - FRAC_W;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_W - 1));
  localparam logic signed [RND_W-1:0] SAT_MAX    = RND_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [RND_W-1:0] SAT_MIN    = RND_W'(-(2 ** (SAMPLE_W - 1)));

  typedef enum logic [1:0] {
    CMD_FILTER  = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_WRITE_A = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic             hist_clear;
    logic             shift_in;
    logic             coef_we_b;
    logic             coef_we_a;
    logic [TAP_W-1:0] coef_idx;
    logic [TAP_W-1:0] order;
    logic             mac_en;
    logic             mac_fb;
    logic [TAP_W-1:0] tap;
    logic             round_en;
    logic             out_load;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/iirdf1_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf1_ctrl
// sequencer: handshakes, order register and the multiply-accumulate walk
// ----------------------------------------------------------------------------
module iirdf1_ctrl import iirdf1_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  wire cmd_e             command_i,
  input  wire logic [TAP_W-1:0] coef_index_i,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [TAP_W-1:0] cfg_data_i,
  output dp_cmd_t               cmd_o
);

  state_e           state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic             fb_q, fb_d;
  logic             out_valid_q, out_valid_d;
  logic [TAP_W-1:0] active_order_q;
  logic [TAP_W-1:0] order_sat;
  logic             accept;
  logic             last_tap;
  logic             out_free;

  assign order_sat = (active_order_q > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : active_order_q;
  assign s_ready_o   = (state_q == ST_IDLE);
  assign accept      = s_valid_i && s_ready_o;
  assign last_tap    = (tap_q == order_sat) && (fb_q || (order_sat == '0));
  assign out_free    = !out_valid_q || m_ready_i;
  assign m_valid_o   = out_valid_q;
  assign cfg_ready_o = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && (command_i == CMD_FILTER)) state_d = ST_MAC;
      ST_MAC:   if (last_tap) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_ROUND;
      ST_ROUND: state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd_o          = '0;
    cmd_o.order    = order_sat;
    cmd_o.coef_idx = coef_index_i;
    cmd_o.tap      = tap_q;
    cmd_o.mac_fb   = fb_q;
    tap_d          = tap_q;
    fb_d           = fb_q;
    unique case (state_q)
      ST_IDLE: begin
        tap_d = '0;
        fb_d  = 1'b0;
        if (accept) begin
          unique case (command_i)
            CMD_FILTER:  cmd_o.shift_in   = 1'b1;
            CMD_WRITE_B: cmd_o.coef_we_b  = (coef_index_i <= TAP_W'(MAX_TAPS));
            CMD_WRITE_A: cmd_o.coef_we_a  = (coef_index_i <= TAP_W'(MAX_TAPS));
            CMD_CLEAR:   cmd_o.hist_clear = 1'b1;
            default:     cmd_o.hist_clear = 1'b0;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (!fb_q && (tap_q == order_sat)) begin
          fb_d  = 1'b1;
          tap_d = TAP_W'(1);
        end else begin
          tap_d = tap_q + TAP_W'(1);
        end
      end
      ST_DRAIN: cmd_o.mac_en = 1'b0;
      ST_ROUND: cmd_o.round_en = 1'b1;
      ST_OUT:   cmd_o.out_load = out_free;
      default:  cmd_o.out_load = 1'b0;
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && !m_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      tap_q          <= '0;
      fb_q           <= 1'b0;
      out_valid_q    <= 1'b0;
      active_order_q <= '0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      fb_q        <= fb_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        active_order_q <= cfg_data_i;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/iirdf1_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf1_dp
// histories, coefficient banks, shared multiplier, accumulator and rounding
// ----------------------------------------------------------------------------
module iirdf1_dp import iirdf1_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dp_cmd_t                    cmd_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic signed [COEF_W-1:0]   coef_value_i,
  output logic signed [SAMPLE_W-1:0]      filtered_sample_o,
  output logic                            saturated_o
);

  logic signed [SAMPLE_W-1:0] x_hist_q [DEPTH];
  logic signed [SAMPLE_W-1:0] y_hist_q [DEPTH];
  logic signed [COEF_W-1:0]   b_coef_q [DEPTH];
  logic signed [COEF_W-1:0]   a_coef_q [DEPTH];

  logic signed [SAMPLE_W-1:0] op_s;
  logic signed [COEF_W-1:0]   op_c;
  logic [TAP_W-1:0]           y_idx;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       prod_vld_q;
  logic                       prod_sub_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [RND_W-1:0]    rnd_q;
  logic                       sat_hi;
  logic                       sat_lo;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic signed [SAMPLE_W-1:0] y_q;
  logic                       sat_q;

  // feedback taps pair a[j] with the output one step older
  assign y_idx = cmd_i.tap - TAP_W'(1);
  assign op_s  = cmd_i.mac_fb ? y_hist_q[y_idx] : x_hist_q[cmd_i.tap];
  assign op_c  = cmd_i.mac_fb ? a_coef_q[cmd_i.tap] : b_coef_q[cmd_i.tap];

  assign acc_rnd = acc_q + ROUND_HALF;
  assign sat_hi  = (rnd_q > SAT_MAX);
  assign sat_lo  = (rnd_q < SAT_MIN);
  assign y_sat   = sat_hi ? SAT_MAX[SAMPLE_W-1:0] :
                   sat_lo ? SAT_MIN[SAMPLE_W-1:0] : rnd_q[SAMPLE_W-1:0];

  // input history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_hist_q <= '{default: '0};
    end else if (cmd_i.hist_clear) begin
      x_hist_q <= '{default: '0};
    end else if (cmd_i.shift_in) begin
      for (int j = 1; j < DEPTH; j++) begin
        if (TAP_W'(j) <= cmd_i.order) x_hist_q[j] <= x_hist_q[j-1];
      end
      x_hist_q[0] <= sample_i;
    end
  end

  // output history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_hist_q <= '{default: '0};
    end else if (cmd_i.hist_clear) begin
      y_hist_q <= '{default: '0};
    end else if (cmd_i.out_load) begin
      for (int j = 1; j < DEPTH; j++) begin
        if (TAP_W'(j) <= cmd_i.order) y_hist_q[j] <= y_hist_q[j-1];
      end
      y_hist_q[0] <= y_sat;
    end
  end

  // coefficient banks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_coef_q <= '{default: '0};
      a_coef_q <= '{default: '0};
    end else begin
      if (cmd_i.coef_we_b) b_coef_q[cmd_i.coef_idx] <= coef_value_i;
      if (cmd_i.coef_we_a) a_coef_q[cmd_i.coef_idx] <= coef_value_i;
    end
  end

  // product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_sub_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac_en;
      prod_sub_q <= cmd_i.mac_fb;
    end
  end

  // multiply, accumulate, round
  always_ff @(posedge clk_i) begin
    prod_q <= op_s * op_c;
    if (cmd_i.shift_in) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= prod_sub_q ? (acc_q - ACC_W'(prod_q)) : (acc_q + ACC_W'(prod_q));
    end
    if (cmd_i.round_en) rnd_q <= acc_rnd[ACC_W-1:FRAC_W];
    if (cmd_i.out_load) begin
      y_q   <= y_sat;
      sat_q <= sat_hi || sat_lo;
    end
  end

  assign filtered_sample_o = y_q;
  assign saturated_o       = sat_q;

endmodule
`default_nettype wire

// ----- rtl/core/iir_direct_form_one_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// direct form I iir filter, programmable order, q8.24 coefficients
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                      | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tuser command, tdata sample/index/coef
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata filtered sample, tuser saturated
//  cfg      | in  | cfg_valid_i / cfg_ready_o      | active order (4 bits)
//
//  for a filter word the single shared 24x32 multiplier walks the 2*n+1
//  products one per cycle, n the active order clipped to 8; the input
//  stays closed from its accept until its result is loaded
//  coefficient writes and clears produce no word
//  reset (rst_ni low, async) zeroes histories, coefficients and the order
//  a result waits in the output register; the next word is accepted
//  meanwhile and only its final load stalls while m_axis_tready is low
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter import iirdf1_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input word
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // sample[23:0], coef_index[27:24],
                                          // coef_value[59:28], zero[63:60]
  input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
  // result word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // filtered_sample[23:0]
  output logic [0:0]       m_axis_tuser,  // saturated[0]
  // order register
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i     // active_order[3:0]
);

  // field positions inside s_axis_tdata
  localparam int IDX_LSB  = SAMPLE_W;
  localparam int COEF_LSB = IDX_LSB + TAP_W;

  dp_cmd_t                    dp_cmd;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [TAP_W-1:0]           in_index;
  logic signed [COEF_W-1:0]   in_coef;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_sat;

  // unpack the input word
  assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
  assign in_index  = s_axis_tdata[COEF_LSB-1:IDX_LSB];
  assign in_coef   = s_axis_tdata[COEF_LSB+COEF_W-1:COEF_LSB];

  // sequencer: owns the handshakes and the order register
  iirdf1_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .command_i    (cmd_e'(s_axis_tuser)),
    .coef_index_i (in_index),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .cmd_o        (dp_cmd)
  );

  // datapath: storage, mac, rounding and result register
  iirdf1_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .sample_i          (in_sample),
    .coef_value_i      (in_coef),
    .filtered_sample_o (out_sample),
    .saturated_o       (out_sat)
  );

  assign m_axis_tdata    = out_sample;
  assign m_axis_tuser[0] = out_sat;

endmodule
`default_nettype wire

// ----- rtl/core/iirdf1_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf1_chk
// port-level checks of the iir filter, bound to the top level
// ----------------------------------------------------------------------------
module iirdf1_chk import iirdf1_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a clipped result sits on one of the rails
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata == 24'h7fffff) || (m_axis_tdata == 24'h800000))
    else $error("saturated flag without rail value");

  // a filter word starts the mac walk, so input closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_FILTER) |=> !s_axis_tready)
    else $error("input open during filter walk");

  // coefficient writes and clears keep the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_FILTER) |=> s_axis_tready)
    else $error("command word stalled the input");

endmodule

bind iir_direct_form_one_filter iirdf1_chk u_iirdf1_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the direct form I iir filter: a queue of command
// and order jobs feeds a clocked driver, a behavioral model of the filter
// predicts every output word, and a clocked monitor compares each word taken
// from the master side against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
  import iirdf1_pkg::*;

  localparam int  CLK_PERIOD     = 10;
  localparam int  RESET_CYCLES   = 11;
  localparam int  SETTLE_CYCLES  = 40;
  localparam int  WATCHDOG_LIMIT = 3000;  // cycles without any handshake
  localparam int  TOTAL_WORDS    = 1000;  // directed plus random input words
  localparam int  SAMPLE_MAX     = 8388607;
  localparam int  SAMPLE_MIN     = -8388608;
  localparam longint ROUND_BIAS  = longint'(1) << 23;

  typedef enum logic [1:0] {
    JOB_WORD,   // one input word on s_axis
    JOB_ORDER,  // order register write, only once the filter is quiet
    JOB_HOLD    // sender waits until every output word has come back
  } job_kind_e;

  typedef struct {
    job_kind_e         kind;
    cmd_e              cmd;
    logic signed [23:0] sample;
    logic [3:0]        idx;
    logic [31:0]       coef;
    logic [3:0]        order;
  } job_t;

  typedef struct {
    logic signed [23:0] value;
    logic               sat;
  } filter_out_t;

  // dut inputs, all known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // sample[23:0], coef_index[27:24],
                                     // coef_value[59:28], zero[63:60]
  logic [1:0]  s_axis_tuser  = '0;   // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // filtered_sample[23:0]
  logic [0:0]  m_axis_tuser;         // saturated[0]
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i    = '0;   // active_order[3:0]

  // stimulus and scoreboard state
  job_t        job_q[$];
  filter_out_t expected_outputs[$];
  int          job_words;       // input words queued so far
  int          words_accepted;
  int          results_due;     // output words predicted so far
  int          results_seen;    // output words taken, updated by nba
  int          quiet_cycles;
  int          stall_cycles;
  int          idle_mode;       // 0: sender 32 / receiver 69, 1: swapped, 2: no idling
  int          failures;

  // behavioral filter state, all zero from time zero
  longint      x_hist[0:MAX_TAPS];
  longint      y_hist[0:MAX_TAPS];
  longint      b_coef[0:MAX_TAPS];
  longint      a_coef[0:MAX_TAPS];
  logic [3:0]  order_reg = '0;

  iir_direct_form_one_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // model of one accepted word: updates coefficients and histories and,
  // for a filter word, predicts the rounded and clipped output
  task automatic iir_update(input cmd_e cmd, input logic signed [23:0] x,
                            input logic [3:0] tap, input logic signed [31:0] coef);
    int          taps;
    longint      acc;
    longint      y;
    filter_out_t out;
    case (cmd)
      CMD_WRITE_B: begin
        if (tap <= MAX_TAPS) b_coef[tap] = coef;
      end
      CMD_WRITE_A: begin
        if (tap <= MAX_TAPS) a_coef[tap] = coef;
      end
      CMD_CLEAR: begin
        for (int k = 0; k <= MAX_TAPS; k++) begin
          x_hist[k] = 0;
          y_hist[k] = 0;
        end
      end
      default: begin
        // orders above the tap count act as the full tap count
        taps = (order_reg > MAX_TAPS) ? MAX_TAPS : int'(order_reg);
        for (int k = taps; k > 0; k--) x_hist[k] = x_hist[k-1];
        x_hist[0] = x;
        acc = 0;
        for (int k = 0; k <= taps; k++) acc += x_hist[k] * b_coef[k];
        for (int k = 1; k <= taps; k++) acc -= y_hist[k-1] * a_coef[k];
        // round half up, then clip to 24 bits
        y = (acc + ROUND_BIAS) >>> 24;
        out.sat = 1'b0;
        if (y > SAMPLE_MAX) begin
          y = SAMPLE_MAX;
          out.sat = 1'b1;
        end else if (y < SAMPLE_MIN) begin
          y = SAMPLE_MIN;
          out.sat = 1'b1;
        end
        out.value = y[23:0];
        for (int k = taps; k > 0; k--) y_hist[k] = y_hist[k-1];
        y_hist[0] = y;
        expected_outputs.push_back(out);
        results_due++;
      end
    endcase
  endtask

  task automatic push_word(input cmd_e cmd, input logic signed [23:0] x,
                           input logic [3:0] tap, input logic [31:0] coef);
    job_t j;
    j.kind   = JOB_WORD;
    j.cmd    = cmd;
    j.sample = x;
    j.idx    = tap;
    j.coef   = coef;
    j.order  = '0;
    job_q.push_back(j);
    job_words++;
  endtask

  task automatic push_order(input logic [3:0] ord);
    job_t j;
    j.kind   = JOB_ORDER;
    j.cmd    = CMD_FILTER;
    j.sample = '0;
    j.idx    = '0;
    j.coef   = '0;
    j.order  = ord;
    job_q.push_back(j);
  endtask

  task automatic push_hold();
    job_t j;
    j.kind   = JOB_HOLD;
    j.cmd    = CMD_FILTER;
    j.sample = '0;
    j.idx    = '0;
    j.coef   = '0;
    j.order  = '0;
    job_q.push_back(j);
  endtask

  // half small samples so the filter stays in range, the rest random or full scale
  function automatic logic signed [23:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? 24'sh7fffff : 24'sh800000;
    if (r < 5)  return 24'($urandom());
    return 24'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  // coefficient within +-2^shift in q8.24, now and then the full 32-bit range
  function automatic logic [31:0] rand_coef(input int shift);
    int lim;
    lim = 1 << shift;
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: takes jobs from the queue, presents words on s_axis and order
  // writes on the cfg channel, and feeds every accepted word to the model
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic        next_valid;
    logic        next_cfg_valid;
    logic [63:0] next_tdata;
    logic [1:0]  next_tuser;
    logic [3:0]  next_cfg;
    int          send_gap;
    job_t        head;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      cfg_valid_i   <= 1'b0;
      cfg_data_i    <= '0;
      idle_mode     <= 0;
    end else begin
      next_valid     = s_axis_tvalid;
      next_cfg_valid = cfg_valid_i;
      next_tdata     = s_axis_tdata;
      next_tuser     = s_axis_tuser;
      next_cfg       = cfg_data_i;
      send_gap       = (idle_mode == 0) ? 32 : (idle_mode == 1) ? 69 : 0;

      // the block counts as quiet once nothing is in flight for a while
      if (s_axis_tvalid || cfg_valid_i || m_axis_tvalid || results_due != results_seen)
        quiet_cycles = 0;
      else
        quiet_cycles++;

      if (s_axis_tvalid && s_axis_tready) begin
        iir_update(cmd_e'(s_axis_tuser), s_axis_tdata[23:0], s_axis_tdata[27:24],
                   s_axis_tdata[59:28]);
        words_accepted++;
        next_valid = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        order_reg      = cfg_data_i;
        next_cfg_valid = 1'b0;
      end

      if (!next_valid && !next_cfg_valid && job_q.size() != 0) begin
        head = job_q[0];
        case (head.kind)
          JOB_WORD: begin
            if ($urandom_range(0, 99) >= send_gap) begin
              next_valid = 1'b1;
              next_tdata = {4'b0000, head.coef, head.idx, head.sample};
              next_tuser = head.cmd;
              job_q.delete(0);
            end
          end
          JOB_ORDER: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              next_cfg_valid = 1'b1;
              next_cfg       = head.order;
              job_q.delete(0);
            end
          end
          default: begin
            if (quiet_cycles >= SETTLE_CYCLES) job_q.delete(0);
          end
        endcase
      end

      s_axis_tvalid <= next_valid;
      s_axis_tdata  <= next_tdata;
      s_axis_tuser  <= next_tuser;
      cfg_valid_i   <= next_cfg_valid;
      cfg_data_i    <= next_cfg;
      // idling pattern follows progress through the stimulus
      idle_mode     <= (words_accepted < TOTAL_WORDS / 3)     ? 0 :
                       (words_accepted < 2 * TOTAL_WORDS / 3) ? 1 : 2;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure on m_axis, each output word checked
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    filter_out_t want;
    int          recv_gap;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      recv_gap = (idle_mode == 0) ? 69 : (idle_mode == 1) ? 32 : 0;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (expected_outputs.size() == 0) begin
          $error("unexpected output word: filtered_sample %0d saturated %0d",
                 $signed(m_axis_tdata), m_axis_tuser[0]);
          failures++;
        end else begin
          want = expected_outputs.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("filtered_sample: expected %0d, got %0d", want.value,
                   $signed(m_axis_tdata));
            failures++;
          end
          if (m_axis_tuser[0] !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, m_axis_tuser[0]);
            failures++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_gap);
    end
  end

  // watchdog: no handshake of any kind for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int         seg;
    int         taps;
    int         burst;
    int         r;
    logic [3:0] ord;

    job_words = 0;

    // directed: order zero, all coefficients still zero after reset
    push_word(CMD_FILTER, 24'sh7fffff, 4'd0, 32'h0);
    // unity gain passes both sample extremes untouched
    push_word(CMD_WRITE_B, 24'sh0, 4'd0, 32'h0100_0000);
    push_word(CMD_FILTER, 24'sh800000, 4'd5, 32'hffff_ffff);
    push_word(CMD_FILTER, 24'sh7fffff, 4'd0, 32'h0);
    // largest and most negative gain clip in both directions
    push_word(CMD_WRITE_B, 24'sh0, 4'd0, 32'h7fff_ffff);
    push_word(CMD_FILTER, 24'sh7fffff, 4'd0, 32'h0);
    push_word(CMD_FILTER, 24'sh800000, 4'd0, 32'h0);
    push_word(CMD_WRITE_B, 24'sh0, 4'd0, 32'h8000_0000);
    push_word(CMD_FILTER, 24'sh7fffff, 4'd0, 32'h0);
    // half gain: +0.5 rounds up to 1, -0.5 rounds up to 0
    push_word(CMD_WRITE_B, 24'sh0, 4'd0, 32'h0080_0000);
    push_word(CMD_FILTER, 24'sh000001, 4'd0, 32'h0);
    push_word(CMD_FILTER, 24'shffffff, 4'd0, 32'h0);
    // writes past the last tap are dropped, a[0] takes no part
    push_word(CMD_WRITE_B, 24'sh0, 4'd15, 32'h7fff_ffff);
    push_word(CMD_WRITE_A, 24'sh0, 4'd9, 32'h7fff_ffff);
    push_word(CMD_WRITE_A, 24'sh0, 4'd0, 32'h7fff_ffff);
    // full order with taps at both ends of the history
    push_hold();
    push_order(4'd8);
    push_word(CMD_WRITE_B, 24'sh0, 4'd8, 32'h0100_0000);
    push_word(CMD_WRITE_A, 24'sh0, 4'd1, 32'hff80_0000);
    push_word(CMD_WRITE_A, 24'sh0, 4'd8, 32'h0080_0000);
    push_word(CMD_FILTER, 24'sh400000, 4'd0, 32'h0);
    push_word(CMD_FILTER, 24'shc00000, 4'd0, 32'h0);
    push_word(CMD_CLEAR, 24'sh123456, 4'd3, 32'h0);
    push_word(CMD_FILTER, 24'sh000100, 4'd0, 32'h0);
    // order field above the tap count behaves as full order
    push_order(4'd15);
    push_word(CMD_FILTER, 24'sh7fffff, 4'd0, 32'h0);
    push_word(CMD_FILTER, 24'sh800000, 4'd0, 32'h0);

    // random: segments of coefficient loads followed by sample bursts
    seg = 0;
    while (job_words < TOTAL_WORDS) begin
      if (seg % 4 == 3) push_hold();
      case (seg)
        0:       ord = 4'd0;
        1:       ord = 4'd8;
        2:       ord = 4'd15;
        default: ord = 4'($urandom_range(0, 15));
      endcase
      push_order(ord);
      taps = (ord > MAX_TAPS) ? MAX_TAPS : int'(ord);
      for (int k = 0; k <= taps; k++)
        push_word(CMD_WRITE_B, rand_sample(), 4'(k), rand_coef(23));
      for (int k = 1; k <= taps; k++)
        push_word(CMD_WRITE_A, rand_sample(), 4'(k), rand_coef(21));
      if ($urandom_range(0, 1) != 0)
        push_word(CMD_CLEAR, rand_sample(), 4'($urandom()), $urandom());
      burst = $urandom_range(40, 90);
      for (int k = 0; k < burst; k++) begin
        r = $urandom_range(0, 99);
        if (r < 85)
          push_word(CMD_FILTER, rand_sample(), 4'($urandom()), $urandom());
        else if (r < 90)
          push_word(CMD_CLEAR, rand_sample(), 4'($urandom()), $urandom());
        else if (r < 95)
          push_word(CMD_WRITE_B, rand_sample(), 4'($urandom_range(0, 15)), rand_coef(23));
        else
          push_word(CMD_WRITE_A, rand_sample(), 4'($urandom_range(0, 15)), rand_coef(21));
      end
      seg++;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the queue to drain and every output word to come back
    do @(negedge clk_i);
    while (job_q.size() != 0 || s_axis_tvalid || cfg_valid_i || expected_outputs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (expected_outputs.size() != 0) begin
      $error("%0d output words never arrived", expected_outputs.size());
    end
    if (failures == 0 && expected_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
